>>> src/srlm_pkg.sv
// ----------------------------------------------------------------------------
// srlm_pkg: shared constants and types of the smoothed RMS level meter
// Fixed field widths, smoothing coefficients, defaults and sequencer states.
// ----------------------------------------------------------------------------
package srlm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int GAIN_W   = 11;

    localparam int DEF_MAX_SAMPLES = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [15:0]        COEF_OLD   = 16'd60293;
    localparam logic [15:0]        COEF_NEW   = 16'd5243;
    localparam logic [16:0]        ROUND_HALF = 17'd32768;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 16'hFFFF;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 11'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_SMOOTH_OLD,
        ST_SMOOTH_NEW,
        ST_SCALE,
        ST_EMIT
    } srlm_state_t;

    typedef enum logic [1:0] {
        RP_IDLE,
        RP_DIVIDE,
        RP_SQRT
    } srlm_root_phase_t;

endpackage

>>> src/srlm_mul.sv
// ----------------------------------------------------------------------------
// srlm_mul: serial multiply-accumulate
// Computes acc_in + a_in * b_in, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module srlm_mul #(
    parameter int MUL_W = 16,
    parameter int ACC_W = 39
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] acc_in,
    input  logic [MUL_W-1:0] a_in,
    input  logic [MUL_W-1:0] b_in,
    output logic             done,
    output logic [ACC_W-1:0] acc_out
);
    localparam int CW = $clog2(MUL_W + 1);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] a_reg;
    logic [MUL_W-1:0] b_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(MUL_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= acc_in;
            a_reg   <= ACC_W'(a_in);
            b_reg   <= b_in;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign acc_out = acc_reg;

endmodule

>>> src/srlm_root.sv
// ----------------------------------------------------------------------------
// srlm_root: serial mean and square root
// Restoring division of the square sum by the count, one quotient bit per
// cycle, then digit-by-digit square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module srlm_root #(
    parameter int SUM_W = 39,
    parameter int CNT_W = 9,
    parameter int RT_W  = (SUM_W + 1) / 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] sum,
    input  logic [CNT_W-1:0] count,
    output logic             done,
    output logic [RT_W-1:0]  root
);
    import srlm_pkg::*;

    localparam int NUM_W  = 2 * RT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    srlm_root_phase_t phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [RT_W+1:0]   srem_reg, srem_next;
    logic [RT_W-1:0]   root_reg, root_next;

    logic [CNT_W:0]    div_trial;
    logic [CNT_W:0]    div_diff;
    logic              div_fits;
    logic [RT_W+3:0]   sq_shifted;
    logic [RT_W+3:0]   sq_trial;
    logic [RT_W+3:0]   sq_diff;
    logic              sq_fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= RP_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        div_trial  = {rem_reg, num_reg[SUM_W-1]};
        div_fits   = div_trial >= {1'b0, den_reg};
        div_diff   = div_trial - {1'b0, den_reg};
        sq_shifted = {srem_reg, num_reg[NUM_W-1 -: 2]};
        sq_trial   = (RT_W + 4)'({root_reg, 2'b01});
        sq_fits    = sq_shifted >= sq_trial;
        sq_diff    = sq_shifted - sq_trial;

        phase_next = phase_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;

        unique case (phase_reg)
            RP_IDLE:
            begin
                if (start)
                begin
                    rem_next  = '0;
                    den_next  = count;
                    srem_next = '0;
                    root_next = '0;
                    if (count == '0)
                    begin
                        num_next   = '0;
                        phase_next = RP_SQRT;
                        step_next  = STEP_W'(RT_W);
                    end
                    else
                    begin
                        num_next   = NUM_W'(sum);
                        phase_next = RP_DIVIDE;
                        step_next  = STEP_W'(SUM_W);
                    end
                end
            end
            RP_DIVIDE:
            begin
                num_next  = NUM_W'({num_reg[SUM_W-2:0], div_fits});
                rem_next  = div_fits ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    phase_next = RP_SQRT;
                    step_next  = STEP_W'(RT_W);
                end
            end
            RP_SQRT:
            begin
                num_next  = num_reg << 2;
                srem_next = sq_fits ? sq_diff[RT_W+1:0] : sq_shifted[RT_W+1:0];
                root_next = {root_reg[RT_W-2:0], sq_fits};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    phase_next = RP_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = RP_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> src/smoothed_rms_level_meter.sv
// ----------------------------------------------------------------------------
// smoothed_rms_level_meter: buffer RMS with exponential smoothing and gain
// Accumulates squared samples per buffer; on the last sample takes the mean,
// its square root, the smoothed level and the gain-scaled level.
//
//   channel   handshake                  payload
//   in        in_valid / in_stall        sample, last_in_buffer
//   out       out_valid / out_stall      rms_level, smoothed_level,
//                                        scaled_level, overrun
//   config    volume_gain_write          volume_gain
//
// Samples past MAX_SAMPLES in a buffer are dropped and flag an overrun. A last
// sample then runs a restoring division, a square root and three serial
// products (old smoothed level, new level, gain). in_stall is high while an
// item is at work. A finished result waits in the output register; new samples
// are taken meanwhile. Reset clears the buffer and the smoothed level and sets
// the gain to 4.0 at the default sample width.
// ----------------------------------------------------------------------------
module smoothed_rms_level_meter #(
    parameter int MAX_SAMPLES = srlm_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = srlm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                volume_gain_write,
    input  logic [srlm_pkg::GAIN_W-1:0]         volume_gain,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [srlm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_in_buffer,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [srlm_pkg::LEVEL_W-1:0]        rms_level,
    output logic [srlm_pkg::LEVEL_W-1:0]        smoothed_level,
    output logic [srlm_pkg::LEVEL_W-1:0]        scaled_level,
    output logic                                overrun
);
    import srlm_pkg::*;

    localparam int MW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int ACC_W = (SUM_W > 2 * MW + 1) ? SUM_W : 2 * MW + 1;
    localparam int RT_W  = (SUM_W + 1) / 2;
    localparam int RW    = (RT_W > LEVEL_W) ? RT_W : LEVEL_W;
    localparam int SHR   = (SAMPLE_BITS >= 10) ? SAMPLE_BITS - 10 : 0;
    localparam int SHL   = (SAMPLE_BITS >= 10) ? 0 : 10 - SAMPLE_BITS;

    srlm_state_t state_reg, state_next;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LEVEL_W-1:0] smooth_reg, smooth_next;
    logic               overrun_reg, overrun_next;
    logic               last_reg, last_next;
    logic [GAIN_W-1:0]  gain_reg;

    logic [LEVEL_W-1:0] rms_reg, rms_next;
    logic [LEVEL_W-1:0] scaled_reg, scaled_next;

    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] rms_out_reg, rms_out_next;
    logic [LEVEL_W-1:0] smooth_out_reg, smooth_out_next;
    logic [LEVEL_W-1:0] scaled_out_reg, scaled_out_next;
    logic               overrun_out_reg, overrun_out_next;

    logic [MW-1:0]          sample_ext;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   in_xfer;
    logic                   full;

    logic               mul_start;
    logic [ACC_W-1:0]   mul_acc_in;
    logic [MW-1:0]      mul_a;
    logic [MW-1:0]      mul_b;
    logic               mul_done;
    logic [ACC_W-1:0]   mul_acc_out;

    logic               root_start;
    logic               root_done;
    logic [RT_W-1:0]    root_val;

    logic [ACC_W-17:0]  smooth_wide;
    logic [ACC_W-1:0]   scaled_wide;

    srlm_mul #(
        .MUL_W (MW),
        .ACC_W (ACC_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .acc_in  (mul_acc_in),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .acc_out (mul_acc_out)
    );

    srlm_root #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W),
        .RT_W  (RT_W)
    ) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .sum   (sum_next),
        .count (count_next),
        .done  (root_done),
        .root  (root_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            smooth_reg    <= '0;
            overrun_reg   <= 1'b0;
            last_reg      <= 1'b0;
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            smooth_reg    <= smooth_next;
            overrun_reg   <= overrun_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (volume_gain_write)
            begin
                gain_reg <= volume_gain;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rms_reg         <= rms_next;
        scaled_reg      <= scaled_next;
        rms_out_reg     <= rms_out_next;
        smooth_out_reg  <= smooth_out_next;
        scaled_out_reg  <= scaled_out_next;
        overrun_out_reg <= overrun_out_next;
    end

    always_comb
    begin
        sample_ext  = MW'($unsigned(sample));
        raw         = sample_ext[SAMPLE_BITS-1:0];
        mag         = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
        in_xfer     = in_valid && (state_reg == ST_IDLE);
        full        = count_reg == CNT_W'(MAX_SAMPLES);
        smooth_wide = mul_acc_out[ACC_W-1:16];
        scaled_wide = (mul_acc_out >> SHR) << SHL;

        state_next       = state_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        smooth_next      = smooth_reg;
        overrun_next     = overrun_reg;
        last_next        = last_reg;
        rms_next         = rms_reg;
        scaled_next      = scaled_reg;
        out_valid_next   = out_valid_reg && out_stall;
        rms_out_next     = rms_out_reg;
        smooth_out_next  = smooth_out_reg;
        scaled_out_next  = scaled_out_reg;
        overrun_out_next = overrun_out_reg;
        mul_start        = 1'b0;
        mul_acc_in       = '0;
        mul_a            = '0;
        mul_b            = '0;
        root_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next = last_in_buffer;
                    if (full)
                    begin
                        overrun_next = 1'b1;
                        if (last_in_buffer)
                        begin
                            root_start = 1'b1;
                            state_next = ST_ROOT;
                        end
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_acc_in = ACC_W'(sum_reg);
                        mul_a      = MW'(mag);
                        mul_b      = MW'(mag);
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                if (mul_done)
                begin
                    sum_next   = mul_acc_out[SUM_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    if (last_reg)
                    begin
                        root_start = 1'b1;
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    if (RW'(root_val) > RW'(LEVEL_MAX))
                    begin
                        rms_next = LEVEL_MAX;
                    end
                    else
                    begin
                        rms_next = LEVEL_W'(root_val);
                    end
                    mul_start  = 1'b1;
                    mul_acc_in = ACC_W'(ROUND_HALF);
                    mul_a      = MW'(COEF_OLD);
                    mul_b      = MW'(smooth_reg);
                    state_next = ST_SMOOTH_OLD;
                end
            end
            ST_SMOOTH_OLD:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_acc_in = mul_acc_out;
                    mul_a      = MW'(COEF_NEW);
                    mul_b      = MW'(rms_reg);
                    state_next = ST_SMOOTH_NEW;
                end
            end
            ST_SMOOTH_NEW:
            begin
                if (mul_done)
                begin
                    if (smooth_wide > (ACC_W - 16)'(LEVEL_MAX))
                    begin
                        smooth_next = LEVEL_MAX;
                    end
                    else
                    begin
                        smooth_next = LEVEL_W'(smooth_wide);
                    end
                    mul_start  = 1'b1;
                    mul_acc_in = '0;
                    mul_a      = MW'(gain_reg);
                    mul_b      = MW'(smooth_next);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (mul_done)
                begin
                    if (scaled_wide > ACC_W'(LEVEL_MAX))
                    begin
                        scaled_next = LEVEL_MAX;
                    end
                    else
                    begin
                        scaled_next = LEVEL_W'(scaled_wide);
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    rms_out_next     = rms_reg;
                    smooth_out_next  = smooth_reg;
                    scaled_out_next  = scaled_reg;
                    overrun_out_next = overrun_reg;
                    sum_next         = '0;
                    count_next       = '0;
                    overrun_next     = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall       = state_reg != ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign rms_level      = rms_out_reg;
    assign smoothed_level = smooth_out_reg;
    assign scaled_level   = scaled_out_reg;
    assign overrun        = overrun_out_reg;

endmodule

>>> dv/tb_smoothed_rms_level_meter.sv
// ----------------------------------------------------------------------------
// tb_smoothed_rms_level_meter: self-checking bench for the RMS level meter
// Streams buffers of audio samples through the block under random idling on
// both channels. A bit-accurate predictor tracks the running square sum, the
// smoothed level and the gain, and each result transfer is compared field by
// field with the oldest predicted level. Short directed buffers hit full
// scale, silence and rounding; random buffers vary length, loudness and gain,
// and one buffer runs past the maximum length.
// ----------------------------------------------------------------------------
module tb_smoothed_rms_level_meter;

    import srlm_pkg::*;

    localparam int          MAX_BUFFER    = 256;
    localparam int          SETTLE_CYCLES = 256;
    localparam logic [63:0] SMOOTH_KEEP   = 64'd60293;
    localparam logic [63:0] SMOOTH_TAKE   = 64'd5243;
    localparam logic [63:0] FULL_LEVEL    = 64'd65535;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } audio_xfer_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] smoothed;
        logic [LEVEL_W-1:0] scaled;
        logic               overrun;
    } level_result_t;

    logic                       clk               = 1'b0;
    logic                       rst_n             = 1'b0;
    logic                       volume_gain_write = 1'b0;
    logic [GAIN_W-1:0]          volume_gain       = '0;
    logic                       in_valid          = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample            = '0;
    logic                       last_in_buffer    = 1'b0;
    logic                       out_valid;
    logic                       out_stall         = 1'b0;
    logic [LEVEL_W-1:0]         rms_level;
    logic [LEVEL_W-1:0]         smoothed_level;
    logic [LEVEL_W-1:0]         scaled_level;
    logic                       overrun;

    audio_xfer_t   sample_q[$];
    level_result_t level_q[$];
    audio_xfer_t   next_xfer;

    logic [38:0]        square_total   = '0;
    logic [8:0]         buffer_count   = '0;
    logic               buffer_overrun = 1'b0;
    logic [LEVEL_W-1:0] level_state    = '0;
    logic [GAIN_W-1:0]  gain_setting   = 11'd256;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned mismatch_count = 0;

    smoothed_rms_level_meter i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .volume_gain_write (volume_gain_write),
        .volume_gain       (volume_gain),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .last_in_buffer    (last_in_buffer),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .rms_level         (rms_level),
        .smoothed_level    (smoothed_level),
        .scaled_level      (scaled_level),
        .overrun           (overrun)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] value, input logic last);
        logic [SAMPLE_W-1:0] mag;
        logic [63:0]         mean;
        logic [63:0]         root;
        logic [63:0]         blend;
        logic [63:0]         gained;
        level_result_t       res;
        mag = value[SAMPLE_W-1] ? SAMPLE_W'(~value + 1'b1) : value;
        if (buffer_count >= MAX_BUFFER)
            buffer_overrun = 1'b1;
        else
        begin
            square_total = square_total + 39'(mag) * 39'(mag);
            buffer_count = buffer_count + 1'b1;
        end
        if (last)
        begin
            mean = (buffer_count != 0) ? 64'(square_total) / 64'(buffer_count) : 64'd0;
            root = floor_sqrt(mean);
            if (root > FULL_LEVEL)
                root = FULL_LEVEL;
            blend = (SMOOTH_KEEP * 64'(level_state) + SMOOTH_TAKE * root + 64'd32768) >> 16;
            if (blend > FULL_LEVEL)
                blend = FULL_LEVEL;
            level_state = blend[LEVEL_W-1:0];
            gained = (64'(gain_setting) * blend) >> 6;
            if (gained > FULL_LEVEL)
                gained = FULL_LEVEL;
            res.rms      = root[LEVEL_W-1:0];
            res.smoothed = blend[LEVEL_W-1:0];
            res.scaled   = gained[LEVEL_W-1:0];
            res.overrun  = buffer_overrun;
            level_q.insert(level_q.size(), res);
            square_total   = '0;
            buffer_count   = '0;
            buffer_overrun = 1'b0;
        end
    endtask

    task automatic check_level();
        level_result_t want;
        if (level_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result rms=%0d", rms_level));
            return;
        end
        want = level_q.pop_front();
        if (rms_level !== want.rms)
            report_mismatch($sformatf("rms_level got %0d want %0d", rms_level, want.rms));
        if (smoothed_level !== want.smoothed)
            report_mismatch($sformatf("smoothed_level got %0d want %0d",
                                      smoothed_level, want.smoothed));
        if (scaled_level !== want.scaled)
            report_mismatch($sformatf("scaled_level got %0d want %0d",
                                      scaled_level, want.scaled));
        if (overrun !== want.overrun)
            report_mismatch($sformatf("overrun got %0b want %0b", overrun, want.overrun));
    endtask

    // hold the payload while stalled, advance only after a transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_xfer = sample_q.pop_front();
                in_valid       <= 1'b1;
                sample         <= next_xfer.value;
                last_in_buffer <= next_xfer.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                accumulate_sample(sample, last_in_buffer);
            if (out_valid && !out_stall)
                check_level();
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned style);
        if (style <= 3)
            return SAMPLE_W'($urandom);
        if (style <= 5)
            return SAMPLE_W'($urandom_range(512) - 256);
        if (style == 9)
            return '0;
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            3: return SAMPLE_W'($urandom_range(32767, 24576));
            default: return SAMPLE_W'(-$urandom_range(32768, 24576));
        endcase
    endfunction

    task automatic queue_sample(input logic [SAMPLE_W-1:0] value, input logic last);
        audio_xfer_t x;
        x.value = value;
        x.last  = last;
        sample_q.insert(sample_q.size(), x);
    endtask

    task automatic queue_buffer(input int unsigned len, input int unsigned style);
        for (int unsigned i = 0; i < len; i++)
            queue_sample(pick_sample(style), i == len - 1);
    endtask

    task automatic settle();
        while (sample_q.size() != 0 || in_valid || level_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        @(posedge clk);
        volume_gain_write <= 1'b1;
        volume_gain       <= g;
        gain_setting = g;
        @(posedge clk);
        volume_gain_write <= 1'b0;
    endtask

    task automatic run_segment(input logic [GAIN_W-1:0] g, input int unsigned items,
                               input bit long_buffer);
        int unsigned n;
        int unsigned len;
        write_gain(g);
        n = 0;
        while (n < items)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            queue_buffer(len, $urandom_range(9));
            n += len;
        end
        if (long_buffer)
            queue_buffer(MAX_BUFFER + $urandom_range(1, 4), $urandom_range(9));
        settle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 84;
        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h0000, 1'b1);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hFFFF, 1'b1);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'd3, 1'b0);
        queue_sample(16'd4, 1'b1);
        queue_sample(16'd100, 1'b0);
        queue_sample(-16'sd100, 1'b0);
        queue_sample(16'd100, 1'b1);
        for (int i = 0; i < 8; i++)
            queue_sample(i[0] ? -16'sd16384 : 16'sd16384, i == 7);
        settle();

        run_segment(11'd0, 20, 1'b0);
        run_segment(11'd2047, 20, 1'b0);

        send_idle_pct = 84;
        recv_idle_pct = 38;
        run_segment(11'd1280, 20, 1'b0);
        run_segment(GAIN_W'($urandom_range(2047)), 20, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_segment(11'd1, 20, 1'b1);
        run_segment(GAIN_W'($urandom_range(2047)), 20, 1'b0);

        if (level_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", level_q.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout waiting for the level meter");
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> smoothed_rms_level_meter.f
src/srlm_pkg.sv
src/srlm_mul.sv
src/srlm_root.sv
src/smoothed_rms_level_meter.sv
dv/tb_smoothed_rms_level_meter.sv
